### sv/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

    // frame geometry
    localparam int IMG_WIDTH  = 640;
    localparam int IMG_HEIGHT = 480;
    localparam int PIXELS     = IMG_WIDTH * IMG_HEIGHT;
    localparam int ADDR_W     = $clog2(PIXELS);
    localparam int FILL_W     = $clog2(PIXELS + 1);

    // field widths
    localparam int DEPTH_W = 16;
    localparam int OUT_W   = 17;
    localparam int SUM_W   = 40;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

    // register defaults
    localparam logic [CFG_W-1:0] CUT_RESET      = 16'd800;
    localparam logic [CFG_W-1:0] NEAR_RESET     = 16'd500;
    localparam logic [CFG_W-1:0] CHANGE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] PRESENCE_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CUT      = 4'd0,
        REG_NEAR     = 4'd1,
        REG_CHANGE   = 4'd2,
        REG_PRESENCE = 4'd3
    } reg_idx_t;

    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic               motion_enable;
        logic               cut_enable;
        logic               pose_enable;
        logic               last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] depth_out;
        logic                    motion_mark;
        logic                    frame_end;
        logic [SUM_W-1:0]        depth_sum;
        logic                    pose_request;
    } pixel_out_t;

    // one store entry: previous final depth and motion mark
    typedef struct packed {
        logic signed [OUT_W-1:0] depth;
        logic                    mark;
    } entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] cut_mm;
        logic [CFG_W-1:0] near_limit_mm;
        logic [CFG_W-1:0] change_mm;
        logic [CFG_W-1:0] presence_mm;
    } cfg_t;

    // pixel in the update stage with its store address
    typedef struct packed {
        pixel_in_t pix;
        addr_t     addr;
    } stage_t;

endpackage

### sv/dmc_stream_if.sv
`timescale 1ns / 1ps

// input pixel beats
interface dmc_pixel_if import dmc_pkg::*; ();
    logic      valid;
    logic      ready;
    pixel_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// result beats
interface dmc_result_if import dmc_pkg::*; ();
    logic       valid;
    logic       ready;
    pixel_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/depth_motion_mask_and_cut_core.sv
`timescale 1ns / 1ps
// path: a pixel beat is registered into the update stage, then into the output register
// throughput: one pixel per cycle while result.ready holds, set by one read-modify-write of the pixel store
//   per pixel; a rewrite of the entry just read is forwarded, so no stall
// reset: registers return to defaults, index, sum and fill count clear at once;
//   the store is not swept, entries past the fill count read as zero
module depth_motion_mask_and_cut_core import dmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    dmc_pixel_if.sink            pixel,
    dmc_result_if.source         result
);

    cfg_t              cfg_reg;
    addr_t             idx_reg;
    addr_t             idx_next;
    logic [FILL_W-1:0] fill_reg;
    logic              stage_valid_reg;
    stage_t            stage_reg;
    logic              fwd_hit_reg;
    entry_t            fwd_data_reg;
    logic              rd_ok_reg;

    logic              in_fire;
    logic              advance;
    entry_t            rd_data;
    entry_t            wr_entry;
    entry_t            prev;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cut_mm        <= CUT_RESET;
            cfg_reg.near_limit_mm <= NEAR_RESET;
            cfg_reg.change_mm     <= CHANGE_RESET;
            cfg_reg.presence_mm   <= PRESENCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CUT:      cfg_reg.cut_mm        <= cfg_data;
                REG_NEAR:     cfg_reg.near_limit_mm <= cfg_data;
                REG_CHANGE:   cfg_reg.change_mm     <= cfg_data;
                REG_PRESENCE: cfg_reg.presence_mm   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign pixel.ready = !stage_valid_reg || advance;
    assign in_fire     = pixel.valid && pixel.ready;

    // pixel position, wraps at frame size and restarts after frame end
    always_comb
    begin
        if (pixel.data.last_pixel || (idx_reg == LAST_ADDR))
        begin
            idx_next = '0;
        end
        else
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (in_fire)
        begin
            idx_reg <= idx_next;
        end
    end

    // written entries always form a prefix starting at zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (advance && (FILL_W'(stage_reg.addr) >= fill_reg))
        begin
            fill_reg <= FILL_W'(stage_reg.addr) + 1'b1;
        end
    end

    // update stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // stage payload, forward of a write to the entry being read
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg.pix  <= pixel.data;
            stage_reg.addr <= idx_reg;
            fwd_hit_reg    <= advance && (stage_reg.addr == idx_reg);
            fwd_data_reg   <= wr_entry;
            rd_ok_reg      <= FILL_W'(idx_reg) < fill_reg;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            prev = fwd_data_reg;
        end
        else if (rd_ok_reg)
        begin
            prev = rd_data;
        end
        else
        begin
            prev = '0;
        end
    end

    dmc_store u_store
    (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (idx_reg),
        .rd_data (rd_data),
        .wr_en   (advance),
        .wr_addr (stage_reg.addr),
        .wr_data (wr_entry)
    );

    dmc_update u_update
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .stage_valid (stage_valid_reg),
        .stage       (stage_reg),
        .prev        (prev),
        .advance     (advance),
        .wr_entry    (wr_entry),
        .result      (result)
    );

endmodule

### sv/dmc_store.sv
`timescale 1ns / 1ps

module dmc_store import dmc_pkg::*;
(
    input  logic   clk,
    input  logic   rd_en,
    input  addr_t  rd_addr,
    output entry_t rd_data,
    input  logic   wr_en,
    input  addr_t  wr_addr,
    input  entry_t wr_data
);

    entry_t mem [PIXELS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/dmc_update.sv
`timescale 1ns / 1ps

module dmc_update import dmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          stage_valid,
    input  stage_t        stage,
    input  entry_t        prev,
    output logic          advance,
    output entry_t        wr_entry,
    dmc_result_if.source  result
);

    logic [SUM_W-1:0]        sum_reg;
    logic [SUM_W-1:0]        sum_next;
    logic                    out_valid_reg;
    pixel_out_t              out_reg;
    pixel_out_t              out_next;

    logic signed [OUT_W-1:0] a17;
    logic signed [OUT_W-1:0] near17;
    logic signed [OUT_W:0]   diff;
    logic [OUT_W:0]          abs_diff;
    logic                    move;
    logic                    mark;
    logic                    cut_on;
    logic                    discard;
    logic                    add;
    logic [SUM_W:0]          sum_wide;

    assign advance = stage_valid && (!out_valid_reg || result.ready);

    // motion test against the previous final depth
    always_comb
    begin
        a17      = $signed({1'b0, stage.pix.depth_mm});
        near17   = $signed({1'b0, cfg.near_limit_mm});
        diff     = {a17[OUT_W-1], a17} - {prev.depth[OUT_W-1], prev.depth};
        abs_diff = diff[OUT_W] ? $unsigned(-diff) : $unsigned(diff);
        move     = (stage.pix.depth_mm != '0) && (prev.depth > 17'sd0)
                   && (a17 < near17) && (prev.depth < near17)
                   && (abs_diff > {2'b00, cfg.change_mm});
        mark     = stage.pix.motion_enable ? move : prev.mark;
    end

    // background cut and saturating frame sum
    always_comb
    begin
        cut_on   = stage.pix.cut_enable || stage.pix.pose_enable;
        discard  = cut_on && (stage.pix.depth_mm > cfg.cut_mm);
        add      = cut_on && !discard && (stage.pix.depth_mm != '0);
        sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(stage.pix.depth_mm);
        if (add)
        begin
            sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    // result and write-back entry
    always_comb
    begin
        out_next.depth_out    = discard ? -17'sd1 : a17;
        out_next.motion_mark  = mark;
        out_next.frame_end    = stage.pix.last_pixel;
        out_next.depth_sum    = sum_next;
        out_next.pose_request = stage.pix.last_pixel && stage.pix.pose_enable
                                && (sum_next > SUM_W'(cfg.presence_mm));
        wr_entry.depth        = out_next.depth_out;
        wr_entry.mark         = mark;
    end

    // frame sum, restarts after frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (advance)
        begin
            sum_reg <= stage.pix.last_pixel ? '0 : sum_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule
